// File: hw/rtl/batch_euclidean_distance_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Euclidean distance engine.
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BATCH_EUCLIDEAN_DISTANCE_DEFINES_SVH
`define BATCH_EUCLIDEAN_DISTANCE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BED_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BED_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error(msg);

`endif

// File: hw/rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Shared constants and types for the Euclidean distance engine.
// ----------------------------------------------------------------------------
package bed_pkg;

  // Query store depth and derived address width
  localparam int MAX_DIM = 1024;
  localparam int ADDR_W  = $clog2(MAX_DIM);

  // Field and state widths
  localparam int POS_W  = 11;
  localparam int ELEM_W = 16;
  localparam int DIFF_W = ELEM_W + 1;
  localparam int SQ_W   = 2 * ELEM_W;
  localparam int SUM_W  = 42;
  localparam int ROOT_W = 21;
  localparam int CNT_W  = 16;

  localparam logic [POS_W-1:0] POS_MAX     = '1;
  localparam logic [POS_W-1:0] MAX_DIM_POS = POS_W'(MAX_DIM);
  localparam logic [POS_W-1:0] DIM_RESET   = POS_W'(1024);

  // Input commands
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_CAND  = 1'b1;

  // Square root unit status
  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_result_t;

endpackage

// File: hw/rtl/batch_euclidean_distance.sv
// ----------------------------------------------------------------------------
// batch_euclidean_distance
// Euclidean distance from a stored Q8.8 query vector to streamed candidates.
// ----------------------------------------------------------------------------
//  channel  | handshake             | beat contents
//  ---------+-----------------------+-------------------------------------
//  input    | in_valid / in_ready   | cmd, element, last
//  output   | out_valid / out_ready | distance, vector_number, size_error
//  config   | cfg_valid / cfg_ready | dimension (always ready)
//
//  A query element is written straight into the store.
//  A candidate element is read from the store, squared, then accumulated.
//  A last candidate element also passes through the 21-step root unit and
//  the hand-off into the output register.
//  Reset is synchronous; the query store is not cleared and needs no pass.
//  A stalled output beat holds; new input is taken until a second result waits.
// ----------------------------------------------------------------------------
module batch_euclidean_distance (
  input  logic                         clk,
  input  logic                         rst,
  // input beats
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic signed [bed_pkg::ELEM_W-1:0] element,
  input  logic                         last,
  // result beats
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bed_pkg::ROOT_W-1:0]   distance,
  output logic [bed_pkg::CNT_W-1:0]    vector_number,
  output logic                         size_error,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bed_pkg::POS_W-1:0]    dimension
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]                    state;
  logic [bed_pkg::POS_W-1:0]     dim_reg;
  logic [bed_pkg::POS_W-1:0]     query_position;
  logic [bed_pkg::POS_W-1:0]     element_position;
  logic [bed_pkg::SUM_W-1:0]     square_sum;
  logic [bed_pkg::CNT_W-1:0]     candidate_count;

  logic [bed_pkg::ELEM_W-1:0]    elem_q;
  logic                          last_q;
  logic                          in_range_q;
  logic [bed_pkg::CNT_W-1:0]     vnum_q;
  logic                          serr_q;
  logic [bed_pkg::SQ_W-1:0]      sq;

  logic                          in_acc;
  logic                          out_load;
  logic [bed_pkg::POS_W-1:0]     dim_eff;
  logic [bed_pkg::POS_W-1:0]     qpos_inc;
  logic [bed_pkg::POS_W-1:0]     epos_inc;
  logic [bed_pkg::SUM_W-1:0]     sum_add;
  logic signed [bed_pkg::DIFF_W-1:0]     diff;
  logic signed [2*bed_pkg::DIFF_W-1:0]   prod;

  logic                          q_we;
  logic                          q_re;
  logic [bed_pkg::ELEM_W-1:0]    q_rdata;
  logic                          root_start;
  bed_pkg::root_result_t         root_res;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == ST_HOLD) && (!out_valid || out_ready);

  // effective dimension, clamped to 1..MAX_DIM
  always_comb begin
    if (dim_reg == '0) begin
      dim_eff = bed_pkg::POS_W'(1);
    end else if (dim_reg > bed_pkg::MAX_DIM_POS) begin
      dim_eff = bed_pkg::MAX_DIM_POS;
    end else begin
      dim_eff = dim_reg;
    end
  end

  // saturating position counters
  assign qpos_inc = (query_position < bed_pkg::POS_MAX) ?
                    query_position + 1'b1 : query_position;
  assign epos_inc = (element_position < bed_pkg::POS_MAX) ?
                    element_position + 1'b1 : element_position;

  // query store access
  assign q_we = in_acc && (cmd == bed_pkg::CMD_QUERY) &&
                (query_position < bed_pkg::MAX_DIM_POS);
  assign q_re = in_acc && (cmd == bed_pkg::CMD_CAND);

  bed_query_ram u_query_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (query_position[bed_pkg::ADDR_W-1:0]),
    .wdata (element),
    .re    (q_re),
    .raddr (element_position[bed_pkg::ADDR_W-1:0]),
    .rdata (q_rdata)
  );

  // squared difference and accumulate
  assign diff    = $signed({q_rdata[bed_pkg::ELEM_W-1], q_rdata}) -
                   $signed({elem_q[bed_pkg::ELEM_W-1], elem_q});
  assign prod    = diff * diff;
  assign sum_add = square_sum +
                   (in_range_q ? bed_pkg::SUM_W'(sq) : bed_pkg::SUM_W'(0));

  assign root_start = (state == ST_ACC) && last_q;

  bed_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (sum_add),
    .result  (root_res)
  );

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      dim_reg          <= bed_pkg::DIM_RESET;
      query_position   <= '0;
      element_position <= '0;
      square_sum       <= '0;
      candidate_count  <= '0;
    end else begin
      if (cfg_valid) begin
        dim_reg <= dimension;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (cmd == bed_pkg::CMD_QUERY) begin
              if (last) begin
                query_position   <= '0;
                candidate_count  <= '0;
                element_position <= '0;
                square_sum       <= '0;
              end else begin
                query_position <= qpos_inc;
              end
            end else begin
              if (last) begin
                element_position <= '0;
                candidate_count  <= candidate_count + 1'b1;
              end else begin
                element_position <= epos_inc;
              end
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (last_q) begin
            square_sum <= '0;
            state      <= ST_ROOT;
          end else begin
            square_sum <= sum_add;
            state      <= ST_IDLE;
          end
        end
        ST_ROOT: begin
          if (root_res.done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // per-element payload captured on a candidate beat
  always_ff @(posedge clk) begin
    if (in_acc && (cmd == bed_pkg::CMD_CAND)) begin
      elem_q     <= element;
      last_q     <= last;
      in_range_q <= (element_position < dim_eff);
      vnum_q     <= candidate_count;
      serr_q     <= (epos_inc != dim_eff);
    end
    if (state == ST_MUL) begin
      sq <= prod[bed_pkg::SQ_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      distance      <= root_res.root;
      vector_number <= vnum_q;
      size_error    <= serr_q;
    end
  end

endmodule

// File: hw/rtl/bed_query_ram.sv
// ----------------------------------------------------------------------------
// bed_query_ram
// Query vector store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bed_query_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bed_pkg::ADDR_W-1:0] waddr,
  input  logic [bed_pkg::ELEM_W-1:0] wdata,
  input  logic                       re,
  input  logic [bed_pkg::ADDR_W-1:0] raddr,
  output logic [bed_pkg::ELEM_W-1:0] rdata
);

  logic [bed_pkg::ELEM_W-1:0] mem [bed_pkg::MAX_DIM];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bed_isqrt.sv
// ----------------------------------------------------------------------------
// bed_isqrt
// Iterative floor square root, one result bit per cycle (digit by digit).
// ----------------------------------------------------------------------------
module bed_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bed_pkg::SUM_W-1:0]   operand,
  output bed_pkg::root_result_t       result
);

  localparam int REM_W  = bed_pkg::ROOT_W + 3;
  localparam int STEP_W = $clog2(bed_pkg::ROOT_W);

  logic                        busy;
  logic                        done;
  logic [STEP_W-1:0]           step;
  logic [bed_pkg::SUM_W-1:0]   rad;
  logic [REM_W-1:0]            rem;
  logic [bed_pkg::ROOT_W-1:0]  root;

  logic [REM_W-1:0]            rem_sh;
  logic [REM_W-1:0]            trial;
  logic                        fits;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[bed_pkg::SUM_W-1 -: 2]};
    trial  = REM_W'({root, 2'b01});
    fits   = (rem_sh >= trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(bed_pkg::ROOT_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[bed_pkg::ROOT_W-2:0], fits};
    end
  end

  assign result.done = done;
  assign result.root = root;

endmodule

// File: hw/rtl/bed_checker.sv
// ----------------------------------------------------------------------------
// bed_checker
// Port-level checks on the Euclidean distance engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "batch_euclidean_distance_defines.svh"

module bed_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         cmd,
  input logic [bed_pkg::ELEM_W-1:0]   element,
  input logic                         last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bed_pkg::ROOT_W-1:0]   distance,
  input logic [bed_pkg::CNT_W-1:0]    vector_number,
  input logic                         size_error,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [bed_pkg::POS_W-1:0]    dimension
);

  // a stalled result beat stays up and unchanged
  `BED_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `BED_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(distance) && $stable(vector_number) && $stable(size_error), "stalled result changed")

  // a candidate beat occupies the datapath for the following cycle
  `BED_ASSERT_NEXT(a_cand_busy, in_valid && in_ready && (cmd == bed_pkg::CMD_CAND), !in_ready, "input taken during accumulate")

  // a query beat is a plain store write and leaves the input ready
  `BED_ASSERT_NEXT(a_query_ready, in_valid && in_ready && (cmd == bed_pkg::CMD_QUERY), in_ready, "query beat stalled input")

  // configuration is never back-pressured
  `BED_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind batch_euclidean_distance bed_checker u_bed_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for batch_euclidean_distance. A scripted opening walks
// the corner cases, a preload pass fills the start of the store with extreme
// values and sums them, and randomised phases sweep the dimension register.
// Every distance beat is compared with an in-bench predictor or a scripted value.
// ----------------------------------------------------------------------------
module tb;

  localparam int      SETTLE_CYCLES = 40;
  localparam longint  CYCLE_LIMIT   = 500_000;
  localparam int      PHASE_BEATS   = 104;
  localparam int      RANDOM_PHASES = 8;
  localparam int      PRELOAD_LEN   = 128;

  typedef struct packed {
    logic [bed_pkg::ROOT_W-1:0] root;
    logic [bed_pkg::CNT_W-1:0]  vec;
    logic                       err;
  } distance_rec_t;

  typedef enum logic {ROW_BEAT, ROW_DIM} row_kind_t;

  // one scripted step: an input beat, or a dimension write held in value
  typedef struct packed {
    row_kind_t                  kind;
    logic                       cmd;
    logic [bed_pkg::ELEM_W-1:0] value;
    logic                       last;
    logic                       typed;
    distance_rec_t              want;
  } script_row_t;

  localparam distance_rec_t NO_RES = '0;
  localparam int SCRIPT_ROWS = 24;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // reset dimension is 1024, so a two-element candidate is a size mismatch
    '{ROW_BEAT, bed_pkg::CMD_QUERY, 16'h0100, 1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_QUERY, 16'h0200, 1'b1, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0100, 1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0200, 1'b1, 1'b1, '{21'd0, 16'd0, 1'b1}},
    // exact length, then a short candidate
    '{ROW_DIM,  bed_pkg::CMD_QUERY, 16'd2,    1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0000, 1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0000, 1'b1, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0100, 1'b1, 1'b1, '{21'd0, 16'd2, 1'b1}},
    // long candidate: third element must not be summed
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0000, 1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0000, 1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h7FFF, 1'b1, 1'b0, NO_RES},
    // partial candidate dropped by a query load; counter restarts
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h1234, 1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_QUERY, 16'h8000, 1'b1, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h7FFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0200, 1'b1, 1'b1, '{21'd65535, 16'd0, 1'b0}},
    // short query load keeps entry 1 from before
    '{ROW_BEAT, bed_pkg::CMD_QUERY, 16'h0300, 1'b1, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0300, 1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0200, 1'b1, 1'b1, '{21'd0, 16'd0, 1'b0}},
    // zero dimension behaves as one
    '{ROW_DIM,  bed_pkg::CMD_QUERY, 16'd0,    1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0300, 1'b1, 1'b1, '{21'd0, 16'd1, 1'b0}},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0300, 1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h7FFF, 1'b1, 1'b1, '{21'd0, 16'd2, 1'b1}},
    // oversize dimension behaves as the store depth
    '{ROW_DIM,  bed_pkg::CMD_QUERY, 16'd2047, 1'b0, 1'b0, NO_RES},
    '{ROW_BEAT, bed_pkg::CMD_CAND,  16'h0300, 1'b1, 1'b1, '{21'd0, 16'd3, 1'b1}}
  };

  // DUT connections
  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic                              cmd;
  logic signed [bed_pkg::ELEM_W-1:0] element;
  logic                              last;
  logic                              out_valid;
  logic                              out_ready;
  logic [bed_pkg::ROOT_W-1:0]        distance;
  logic [bed_pkg::CNT_W-1:0]         vector_number;
  logic                              size_error;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [bed_pkg::POS_W-1:0]         dimension;

  // predictor state
  logic [bed_pkg::ELEM_W-1:0] q_mem [bed_pkg::MAX_DIM];
  logic [bed_pkg::POS_W-1:0]  q_wr_pos;
  logic [bed_pkg::POS_W-1:0]  cand_pos;
  logic [bed_pkg::SUM_W-1:0]  sq_acc;
  logic [bed_pkg::CNT_W-1:0]  cand_num;
  logic [bed_pkg::POS_W-1:0]  dim_setting;

  distance_rec_t expected_distances [$];
  int            beats_sent;
  int            distances_checked;
  int            mismatches;
  int            dim_writes;
  bit            flat_out;

  batch_euclidean_distance uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .element       (element),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .distance      (distance),
    .vector_number (vector_number),
    .size_error    (size_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .dimension     (dimension)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    longint cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // zero acts as one, anything past the store depth is clamped
  function automatic logic [bed_pkg::POS_W-1:0] eff_dim(input logic [bed_pkg::POS_W-1:0] d);
    if (d == '0) return bed_pkg::POS_W'(1);
    if (d > bed_pkg::MAX_DIM_POS) return bed_pkg::MAX_DIM_POS;
    return d;
  endfunction

  // floor square root, two bits of radicand per step
  function automatic logic [bed_pkg::ROOT_W-1:0] floor_root(
    input logic [bed_pkg::SUM_W-1:0] x);
    longint unsigned rem;
    longint unsigned acc;
    longint unsigned b;
    rem = x;
    acc = 0;
    b   = 64'd1 << 42;
    while (b != 0) begin
      if (rem >= acc + b) begin
        rem = rem - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return bed_pkg::ROOT_W'(acc);
  endfunction

  function automatic logic [bed_pkg::ELEM_W-1:0] rand_elem();
    unique case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return bed_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  // advance the predicted engine by one accepted beat
  task automatic accumulate_beat(input logic c, input logic [bed_pkg::ELEM_W-1:0] v,
                                 input logic lst,
                                 output bit emits, output distance_rec_t rec);
    logic [bed_pkg::POS_W-1:0] span;
    int                        qv;
    int                        ev;
    longint                    diff;
    span  = eff_dim(dim_setting);
    emits = 1'b0;
    rec   = '0;
    if (c == bed_pkg::CMD_QUERY) begin
      if (q_wr_pos < bed_pkg::MAX_DIM_POS) q_mem[q_wr_pos[bed_pkg::ADDR_W-1:0]] = v;
      if (q_wr_pos != bed_pkg::POS_MAX) q_wr_pos++;
      if (lst) begin
        q_wr_pos = '0;
        cand_num = '0;
        cand_pos = '0;
        sq_acc   = '0;
      end
    end else begin
      if (cand_pos < span) begin
        qv     = $signed(q_mem[cand_pos[bed_pkg::ADDR_W-1:0]]);
        ev     = $signed(v);
        diff   = qv - ev;
        sq_acc = sq_acc + bed_pkg::SUM_W'(diff * diff);
      end
      if (cand_pos != bed_pkg::POS_MAX) cand_pos++;
      if (lst) begin
        emits    = 1'b1;
        rec.root = floor_root(sq_acc);
        rec.vec  = cand_num;
        rec.err  = (cand_pos != span);
        cand_num++;
        cand_pos = '0;
        sq_acc   = '0;
      end
    end
  endtask

  // one input beat after a random gap; typed rows override the prediction
  task automatic send_beat(input logic c, input logic [bed_pkg::ELEM_W-1:0] v,
                           input logic lst,
                           input logic typed, input distance_rec_t want);
    int            gap;
    bit            emits;
    distance_rec_t rec;
    gap = flat_out ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    while (gap > 0) begin
      in_valid <= 1'b0;
      gap--;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    element  <= v;
    last     <= lst;
    do @(posedge clk); while (!in_ready);
    accumulate_beat(c, v, lst, emits, rec);
    if (emits) expected_distances.push_back(typed ? want : rec);
    beats_sent++;
  endtask

  task automatic send_vector(input logic c, input int len);
    for (int i = 0; i < len; i++) send_beat(c, rand_elem(), i == len - 1, 1'b0, NO_RES);
  endtask

  // stop feeding, collect all results, let the pipeline empty
  task automatic drain_to_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dimension(input logic [bed_pkg::POS_W-1:0] d);
    drain_to_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    dimension <= d;
    do @(posedge clk); while (!cfg_ready);
    dim_setting = d;
    dim_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall before each beat, then compare on acceptance
  initial begin
    distance_rec_t want;
    int            stall;
    out_ready = 1'b0;
    @(negedge clk);
    wait (!rst);
    forever begin
      stall = flat_out ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      while (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_distances.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat: expected none, actual dist %0d vec %0d err %0b",
                 $time, distance, vector_number, size_error);
      end else begin
        want = expected_distances.pop_front();
        distances_checked++;
        if (distance !== want.root) begin
          mismatches++;
          $display("%0t: distance: expected %0d, actual %0d", $time, want.root, distance);
        end
        if (vector_number !== want.vec) begin
          mismatches++;
          $display("%0t: vector_number: expected %0d, actual %0d",
                   $time, want.vec, vector_number);
        end
        if (size_error !== want.err) begin
          mismatches++;
          $display("%0t: size_error: expected %0b, actual %0b", $time, want.err, size_error);
        end
      end
    end
  end

  // stimulus
  initial begin
    int                        phase_start;
    int                        pick;
    int                        len;
    int                        bad;
    int                        span_i;
    logic [bed_pkg::POS_W-1:0] pdim;

    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = bed_pkg::CMD_QUERY;
    element     = '0;
    last        = 1'b0;
    cfg_valid   = 1'b0;
    dimension   = bed_pkg::DIM_RESET;
    flat_out    = 1'b0;
    beats_sent  = 0;
    distances_checked = 0;
    mismatches  = 0;
    dim_writes  = 0;
    q_wr_pos    = '0;
    cand_pos    = '0;
    sq_acc      = '0;
    cand_num    = '0;
    dim_setting = bed_pkg::DIM_RESET;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // scripted corner cases
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (SCRIPT[i].kind == ROW_DIM) begin
        write_dimension(bed_pkg::POS_W'(SCRIPT[i].value));
      end else begin
        send_beat(SCRIPT[i].cmd, SCRIPT[i].value, SCRIPT[i].last, SCRIPT[i].typed,
                  SCRIPT[i].want);
      end
    end

    // preload: most negative query against the most positive candidate; this
    // also writes every entry that the random phases go on to read, since no
    // phase gets a candidate past PRELOAD_LEN elements
    write_dimension(bed_pkg::POS_W'(PRELOAD_LEN));
    for (int i = 0; i < PRELOAD_LEN; i++)
      send_beat(bed_pkg::CMD_QUERY, 16'h8000, i == PRELOAD_LEN - 1, 1'b0, NO_RES);
    for (int i = 0; i < PRELOAD_LEN; i++)
      send_beat(bed_pkg::CMD_CAND, 16'h7FFF, i == PRELOAD_LEN - 1, 1'b0, NO_RES);

    // randomised phases, one dimension each
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      unique case (p)
        0:       pdim = bed_pkg::POS_W'(1);
        1:       pdim = bed_pkg::POS_MAX;
        2:       pdim = '0;
        3:       pdim = bed_pkg::MAX_DIM_POS;
        default: pdim = bed_pkg::POS_W'($urandom_range(2, 24));
      endcase
      write_dimension(pdim);
      flat_out    = (p == 5);
      span_i      = int'(eff_dim(pdim));
      phase_start = beats_sent;
      send_vector(bed_pkg::CMD_QUERY, span_i > 32 ? $urandom_range(1, 8) : span_i);
      while (beats_sent - phase_start < PHASE_BEATS) begin
        len  = span_i > 32 ? $urandom_range(1, 8) : span_i;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          send_vector(bed_pkg::CMD_CAND, len);
        end else if (pick < 75) begin
          // length off by a little either way
          bad = len - 1 + $urandom_range(0, 3);
          if (bad == len) bad++;
          if (bad < 1) bad = len + 1;
          send_vector(bed_pkg::CMD_CAND, bad);
        end else if (pick < 85) begin
          send_vector(bed_pkg::CMD_QUERY, $urandom_range(1, len + 2));
        end else if (pick < 92) begin
          send_beat(bed_pkg::CMD_QUERY, rand_elem(), 1'b0, 1'b0, NO_RES);
        end else if (pick < 97) begin
          // candidate cut short by a fresh query
          repeat ($urandom_range(1, len))
            send_beat(bed_pkg::CMD_CAND, rand_elem(), 1'b0, 1'b0, NO_RES);
          send_vector(bed_pkg::CMD_QUERY, len);
        end else begin
          send_beat(1'($urandom_range(0, 1)), rand_elem(), 1'($urandom_range(0, 1)),
                    1'b0, NO_RES);
        end
      end
    end
    flat_out = 1'b0;
    drain_to_idle();

    $display("%0d input beats across %0d dimension writes, %0d distance beats compared",
             beats_sent, dim_writes, distances_checked);
    $display("extreme sums over %0d elements, clamped dimensions and length mismatches",
             PRELOAD_LEN);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
